// ===== src/mpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mpc_pkg;

  localparam int unsigned NumPalettes  = 6;
  localparam int unsigned PalStops     = 6;
  localparam int unsigned PixFieldBits = 12;

  typedef enum logic [2:0] {
    CfgXStart  = 3'd0,
    CfgYStart  = 3'd1,
    CfgXStep   = 3'd2,
    CfgYStep   = 3'd3,
    CfgLimit   = 3'd4,
    CfgPalette = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [PixFieldBits-1:0] pixel_col;
    logic [PixFieldBits-1:0] pixel_row;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch pixel, start mapping
    logic map_x;      // compute c_x
    logic map_y;      // compute c_y
    logic mul;        // compute the three products of z
    logic upd;        // update z
    logic esq;        // square the new z
    logic esc;        // escape compare
    logic pal_mul;    // p = n*(S-1)
    logic div_init;   // start divider
    logic div_step;   // one quotient bit
    logic mix_a;      // channel products
    logic mix_init;   // start channel divider
    logic fin;        // drive result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic escaped;
    logic at_limit;
    logic div_done;
    logic ch_last;
  } dp_sts_t;

  function automatic logic [23:0] pal_rom(input logic [2:0] pal, input logic [2:0] idx);
    logic [23:0] r;
    r = 24'h000000;
    case (pal)
      3'd1: case (idx)
        3'd0: r = {8'd0, 8'd7, 8'd100};
        3'd1: r = {8'd32, 8'd107, 8'd203};
        3'd2: r = {8'd237, 8'd255, 8'd255};
        3'd3: r = {8'd255, 8'd170, 8'd0};
        3'd4: r = {8'd0, 8'd2, 8'd0};
        default: r = 24'h000000;
      endcase
      3'd2: case (idx)
        3'd1: r = {8'd35, 8'd232, 8'd156};
        3'd2: r = {8'd68, 8'd255, 8'd5};
        3'd3: r = {8'd250, 8'd247, 8'd87};
        3'd4: r = {8'd250, 8'd185, 8'd87};
        3'd5: r = {8'd255, 8'd255, 8'd255};
        default: r = 24'h000000;
      endcase
      3'd3: case (idx)
        3'd1: r = {8'd2, 8'd52, 8'd82};
        3'd2: r = {8'd6, 8'd115, 8'd122};
        3'd3: r = {8'd120, 8'd11, 8'd114};
        3'd4: r = {8'd120, 8'd6, 8'd36};
        3'd5: r = {8'd5, 8'd0, 8'd1};
        default: r = 24'h000000;
      endcase
      3'd4: case (idx)
        3'd1: r = {8'd164, 8'd25, 8'd224};
        3'd2: r = {8'd120, 8'd30, 8'd138};
        3'd3: r = {8'd250, 8'd87, 8'd96};
        3'd4: r = {8'd250, 8'd87, 8'd96};
        3'd5: r = {8'd255, 8'd255, 8'd255};
        default: r = 24'h000000;
      endcase
      3'd5: case (idx)
        3'd1: r = {8'd104, 8'd61, 8'd212};
        3'd2: r = {8'd90, 8'd230, 8'd227};
        3'd3: r = {8'd49, 8'd212, 8'd98};
        3'd4: r = {8'd246, 8'd255, 8'd0};
        3'd5: r = {8'd246, 8'd0, 8'd0};
        default: r = 24'h000000;
      endcase
      default: case (idx)
        3'd1: r = {8'd213, 8'd67, 8'd31};
        3'd2: r = {8'd251, 8'd255, 8'd121};
        3'd3: r = {8'd62, 8'd223, 8'd89};
        3'd4: r = {8'd43, 8'd30, 8'd218};
        3'd5: r = {8'd0, 8'd255, 8'd247};
        default: r = 24'h000000;
      endcase
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/mpc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mpc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  output mpc_pkg::dp_cmd_t      cmd_o,
  input  wire mpc_pkg::dp_sts_t sts_i
);
  import mpc_pkg::*;

  typedef enum logic [12:0] {
    StIdle   = 13'b0000000000001,
    StMapX   = 13'b0000000000010,
    StMapY   = 13'b0000000000100,
    StMul    = 13'b0000000001000,
    StUpd    = 13'b0000000010000,
    StSq     = 13'b0000000100000,
    StEsc    = 13'b0000001000000,
    StPal    = 13'b0000010000000,
    StDivI   = 13'b0000100000000,
    StDiv    = 13'b0001000000000,
    StMix    = 13'b0010000000000,
    StMixDiv = 13'b0100000000000,
    StFin    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   mixdiv_q, mixdiv_d;  // divider serves the channel divide

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      mixdiv_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mixdiv_q <= mixdiv_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    mixdiv_d = mixdiv_q;
    cmd_o    = '0;
    busy_o   = (state_q != StIdle);
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StMapX;
        end
      end
      StMapX: begin
        cmd_o.map_x = 1'b1;
        state_d     = StMapY;
      end
      StMapY: begin
        cmd_o.map_y = 1'b1;
        state_d     = sts_i.at_limit ? StPal : StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StUpd;
      end
      StUpd: begin
        cmd_o.upd = 1'b1;
        state_d   = StSq;
      end
      StSq: begin
        cmd_o.esq = 1'b1;
        state_d   = StEsc;
      end
      StEsc: begin
        cmd_o.esc = 1'b1;
        state_d   = (sts_i.escaped || sts_i.at_limit) ? StPal : StMul;
      end
      StPal: begin
        cmd_o.pal_mul = 1'b1;
        mixdiv_d      = 1'b0;
        state_d       = StDivI;
      end
      StDivI: begin
        cmd_o.div_init = 1'b1;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = mixdiv_q ? (sts_i.ch_last ? StFin : StMix) : StMix;
        end
      end
      StMix: begin
        cmd_o.mix_a = 1'b1;
        state_d     = StMixDiv;
      end
      StMixDiv: begin
        cmd_o.mix_init = 1'b1;
        mixdiv_d       = 1'b1;
        state_d        = StDiv;
      end
      StFin: begin
        cmd_o.fin = 1'b1;
        state_d   = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/mpc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mpc_datapath #(
  parameter int unsigned FracBits = 28,
  parameter int unsigned PixBits  = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mpc_pkg::dp_cmd_t  cmd_i,
  output mpc_pkg::dp_sts_t       sts_o,
  input  wire mpc_pkg::pixel_t   pixel_i,
  input  wire logic [31:0]       x_start_i,
  input  wire logic [31:0]       y_start_i,
  input  wire logic [30:0]       x_step_i,
  input  wire logic [30:0]       y_step_i,
  input  wire logic [15:0]       limit_i,
  input  wire logic [2:0]        pal_i,
  output logic                   res_valid_o,
  output mpc_pkg::colour_t       res_o
);
  import mpc_pkg::*;

  localparam int unsigned DivW   = 24;
  // only the low pixel bits that exist on the input are used
  localparam int unsigned PixUse = (PixBits < PixFieldBits) ? PixBits : PixFieldBits;

  logic [PixUse-1:0]  col_q, row_q;
  logic signed [31:0] cx_q, cy_q, x_q, y_q;
  logic signed [63:0] xx_q, yy_q, xy_q;
  logic [15:0]        n_q;
  logic               esc_q;
  logic [2:0]         pal_q;
  logic [2:0]         idx_q;
  logic [15:0]        rem_q;
  logic [1:0]         ch_q;
  logic [DivW-1:0]    dvd_q;
  logic [16:0]        part_q;
  logic [4:0]         cnt_q;
  logic [23:0]        rgb_q;
  logic [23:0]        colour_q;
  logic               valid_q;
  logic               mix_phase_q;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic [15:0] den;
  assign den = (limit_i == 16'd0) ? 16'd1 : limit_i;

  // map pixel to c
  logic signed [45:0] prod_map;
  logic [PixUse-1:0]  pix_sel;
  logic [30:0]        step_sel;
  logic signed [31:0] start_sel;
  assign pix_sel   = cmd_i.map_x ? col_q : row_q;
  assign step_sel  = cmd_i.map_x ? x_step_i : y_step_i;
  assign start_sel = cmd_i.map_x ? x_start_i : y_start_i;
  assign prod_map  = $signed({1'b0, 45'(pix_sel) * 45'(step_sel)});

  // update, arithmetic shift is floor
  logic signed [64:0] dxx;
  logic signed [65:0] nx_full, ny_full;
  logic signed [63:0] xy_sh;
  assign dxx     = 65'(xx_q) - 65'(yy_q);
  assign nx_full = 66'(dxx >>> FracBits) + 66'(cx_q);
  assign xy_sh   = xy_q >>> (FracBits - 1);
  assign ny_full = 66'(xy_sh) + 66'(cy_q);

  // escape test on xx+yy split at bit FracBits, compared with 4
  localparam logic [63:0] FourHi = 64'd4 << FracBits;
  localparam logic [63:0] LoMask = (64'd1 << FracBits) - 64'd1;
  logic [63:0] mag, mag_hi, mag_lo;
  logic        mag_over;
  assign mag      = $unsigned(xx_q) + $unsigned(yy_q);
  assign mag_hi   = mag >> FracBits;
  assign mag_lo   = mag & LoMask;
  assign mag_over = (mag_hi > FourHi) || ((mag_hi == FourHi) && (mag_lo != 64'd0));

  logic [2:0] stops_m1;
  assign stops_m1 = (pal_q == 3'd1) ? 3'd4 : 3'd5;

  // restoring divider, one bit per cycle
  logic [16:0] trial;
  logic        qbit;
  assign trial = {part_q[15:0], dvd_q[DivW-1]};
  assign qbit  = (trial >= {1'b0, den});

  logic [23:0] st_a, st_b;
  assign st_a = pal_rom(pal_q, idx_q);
  assign st_b = pal_rom(pal_q, idx_q + 3'd1);
  logic [7:0] ca, cb;
  always_comb begin
    case (ch_q)
      2'd0:    begin ca = st_a[23:16]; cb = st_b[23:16]; end
      2'd1:    begin ca = st_a[15:8];  cb = st_b[15:8];  end
      default: begin ca = st_a[7:0];   cb = st_b[7:0];   end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q <= pixel_i.pixel_col[PixUse-1:0];
      row_q <= pixel_i.pixel_row[PixUse-1:0];
      pal_q <= (pal_i > 3'd5) ? 3'd0 : pal_i;
      x_q   <= '0;
      y_q   <= '0;
      n_q   <= '0;
      esc_q <= 1'b0;
    end
    if (cmd_i.map_x) cx_q <= sat32(66'(start_sel) + 66'(prod_map));
    if (cmd_i.map_y) cy_q <= sat32(66'(start_sel) + 66'(prod_map));
    if (cmd_i.mul) begin
      xx_q <= x_q * x_q;
      yy_q <= y_q * y_q;
      xy_q <= x_q * y_q;
    end
    if (cmd_i.upd) begin
      x_q <= sat32(nx_full);
      y_q <= sat32(ny_full);
    end
    if (cmd_i.esq) begin
      xx_q <= x_q * x_q;
      yy_q <= y_q * y_q;
    end
    if (cmd_i.esc) begin
      esc_q <= mag_over;
      if (!mag_over) n_q <= n_q + 16'd1;
    end
    if (cmd_i.pal_mul) begin
      // count at limit becomes 0
      dvd_q       <= (esc_q ? 24'(n_q) : 24'd0) * 24'(stops_m1);
      ch_q        <= 2'd0;
      mix_phase_q <= 1'b0;
    end
    if (cmd_i.div_init || cmd_i.mix_init) begin
      part_q <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.div_step) begin
      if (qbit) begin
        part_q <= trial - {1'b0, den};
        dvd_q  <= {dvd_q[DivW-2:0], 1'b1};
      end else begin
        part_q <= trial;
        dvd_q  <= {dvd_q[DivW-2:0], 1'b0};
      end
      cnt_q <= cnt_q + 5'd1;
      // last quotient bit: hand the result to its user
      if (cnt_q == 5'(DivW - 1)) begin
        if (!mix_phase_q) begin
          // quotient/remainder of palette position
          if ({dvd_q[DivW-2:0], qbit} + 24'd1 >= 24'(stops_m1) + 24'd1) begin
            idx_q <= stops_m1 - 3'd1;
            rem_q <= '0;
          end else begin
            idx_q <= 3'({dvd_q[DivW-2:0], qbit});
            rem_q <= qbit ? 16'(trial - {1'b0, den}) : trial[15:0];
          end
          mix_phase_q <= 1'b1;
        end else begin
          case (ch_q)
            2'd0:    rgb_q[23:16] <= {dvd_q[6:0], qbit};
            2'd1:    rgb_q[15:8]  <= {dvd_q[6:0], qbit};
            default: rgb_q[7:0]   <= {dvd_q[6:0], qbit};
          endcase
          ch_q <= ch_q + 2'd1;
        end
      end
    end
    if (cmd_i.mix_a) begin
      dvd_q <= 24'(ca) * 24'(den - rem_q) + 24'(cb) * 24'(rem_q);
    end
    if (cmd_i.fin) colour_q <= rgb_q;
  end

  assign sts_o.escaped  = mag_over;
  assign sts_o.at_limit = cmd_i.map_y ? (limit_i == 16'd0) : (n_q + 16'd1 >= limit_i);
  assign sts_o.div_done = (cnt_q == 5'(DivW - 1));
  assign sts_o.ch_last  = (ch_q == 2'd2);

  assign res_valid_o = valid_q;
  assign res_o       = colour_q;
endmodule
`default_nettype wire

// ===== src/mandelbrot_pixel_colourer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// mandelbrot pixel colourer
// command port: pulse start_i with a pixel while busy_o is low; the pixel is
// taken at that edge and busy_o stays high until the colour is out.
// result: done_o is high for exactly one cycle with the colour on result_o;
// the receiver cannot stall, it must take the beat in that cycle.
// config: cfg_we_i writes register cfg_idx_i (0 x_start .. 5 palette_select)
// from cfg_data_i at once; write only while busy_o is low.
// sequence: from the accepting edge the pixel is mapped (c_x, then c_y),
// then k z updates run (k the limit for a point that never escapes, 0 for
// a zero limit), each on the shared multiplier set (three 32x32 products,
// update, square, compare); the palette step follows (the 24-step
// restoring divider runs once for the palette position and once per
// channel) and the colour is put out last.
// busy_o drops in the result cycle, so a new pixel is taken only after the
// last one is out.
// reset: registers go to their default view window, limit 128, palette 0,
// and the block is idle.
module mandelbrot_pixel_colourer_top #(
  parameter int unsigned COORD_FRAC_BITS = 28,
  parameter int unsigned PIXEL_BITS      = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire mpc_pkg::pixel_t  pixel_i,
  output logic                  done_o,
  output mpc_pkg::colour_t      result_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [31:0]      cfg_data_i
);
  import mpc_pkg::*;

  logic [31:0] x_start_q, y_start_q;
  logic [30:0] x_step_q, y_step_q;
  logic [15:0] limit_q;
  logic [2:0]  pal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_start_q <= 32'hd8000000;
      y_start_q <= 32'hf0000000;
      x_step_q  <= 31'd489335;
      y_step_q  <= 31'd497102;
      limit_q   <= 16'd128;
      pal_q     <= 3'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgXStart:  x_start_q <= cfg_data_i;
        CfgYStart:  y_start_q <= cfg_data_i;
        CfgXStep:   x_step_q  <= cfg_data_i[30:0];
        CfgYStep:   y_step_q  <= cfg_data_i[30:0];
        CfgLimit:   limit_q   <= cfg_data_i[15:0];
        CfgPalette: pal_q     <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t cmd;
  dp_sts_t sts;

  mpc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  mpc_datapath #(
    .FracBits(COORD_FRAC_BITS),
    .PixBits (PIXEL_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .pixel_i    (pixel_i),
    .x_start_i  (x_start_q),
    .y_start_i  (y_start_q),
    .x_step_i   (x_step_q),
    .y_step_i   (y_step_q),
    .limit_i    (limit_q),
    .pal_i      (pal_q),
    .res_valid_o(done_o),
    .res_o      (result_o)
  );
endmodule
`default_nettype wire
